// File: src/dhrt_pkg.sv
`default_nettype none

package dhrt_pkg;

  localparam int unsigned TABLE_SIZE_DEF   = 1021;
  localparam int unsigned STEP_MODULUS_DEF = 719;
  localparam int unsigned MAX_PROBES_DEF   = 64;

  localparam int unsigned OCTET_W          = 8;
  localparam int unsigned IFC_W            = 16;
  localparam int unsigned KEY_W            = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [OCTET_W-1:0] octet_a;
    logic [OCTET_W-1:0] octet_b;
    logic [OCTET_W-1:0] octet_c;
    logic [IFC_W-1:0]   interface_in;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [IFC_W-1:0] interface_out;
    logic             table_full;
  } out_beat_t;

  typedef struct packed {
    logic               valid;
    logic [OCTET_W-1:0] oa;
    logic [OCTET_W-1:0] ob;
    logic [OCTET_W-1:0] oc;
    logic [IFC_W-1:0]   ifc;
  } slot_t;

  typedef struct packed {
    logic start;
    logic home;
    logic flush;
  } step_req_t;

endpackage

`default_nettype wire

// File: src/dhrt_rem.sv
`default_nettype none

module dhrt_rem
  import dhrt_pkg::*;
#(
  parameter int unsigned DIVISOR = 2,
  parameter int unsigned IN_W    = 8,
  localparam int unsigned REM_W  = $clog2(DIVISOR + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IN_W-1:0]  value_i,
  output logic                  done_o,
  output logic [REM_W-1:0]      rem_o
);

  localparam int unsigned LOG_D  = $clog2(DIVISOR);
  localparam int unsigned SHIFT  = IN_W + LOG_D;
  localparam int unsigned MUL_W  = IN_W + 2;
  localparam int unsigned PROD_W = IN_W + MUL_W;
  localparam int unsigned PRD_W  = IN_W + REM_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

  logic [1:0]        phase_q;
  logic              done_q;
  logic [IN_W-1:0]   val_q;
  logic [IN_W-1:0]   quo_q;
  logic [REM_W-1:0]  rem_q;
  logic [PROD_W-1:0] prod;
  logic [PRD_W-1:0]  back;

  assign prod = PROD_W'(val_q) * PROD_W'(RECIP_C);
  assign back = PRD_W'(quo_q) * PRD_W'(DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= {phase_q[0] && !start_i, start_i};
      done_q  <= phase_q[1] && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (phase_q[0]) begin
      quo_q <= IN_W'(prod >> SHIFT);
    end
    if (phase_q[1]) begin
      rem_q <= REM_W'(val_q - IN_W'(back));
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: src/dhrt_step.sv
`default_nettype none

module dhrt_step
  import dhrt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int unsigned STEP_MODULUS = STEP_MODULUS_DEF,
  parameter int unsigned MAX_PROBES   = MAX_PROBES_DEF,
  localparam int unsigned SW          = $clog2(TABLE_SIZE),
  localparam int unsigned CW          = $clog2(MAX_PROBES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire step_req_t        req_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [SW-1:0]    slot_i,
  input  wire logic [CW-1:0]    count_i,
  output logic                  done_o,
  output logic [SW-1:0]         slot_o
);

  localparam int unsigned MW    = $clog2(STEP_MODULUS + 1);
  localparam int unsigned PW    = MW + CW;
  localparam int unsigned NW    = ((SW > PW) ? SW : PW) + 1;
  localparam int unsigned RIN_W = (NW > KEY_W) ? NW : KEY_W;
  localparam int unsigned NRW   = $clog2(TABLE_SIZE + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MREM,
    ST_ADD,
    ST_NREM
  } st_e;

  st_e              state_q;
  logic [SW-1:0]    slot_q;
  logic [CW-1:0]    count_q;
  logic [PW-1:0]    prod_q;

  logic             m_start;
  logic             m_done;
  logic [MW-1:0]    m_rem;
  logic             n_start;
  logic [RIN_W-1:0] n_value;
  logic             n_done;
  logic [NRW-1:0]   n_rem;

  assign m_start = req_i.start && !req_i.home && !req_i.flush;
  assign n_start = !req_i.flush && ((req_i.start && req_i.home) || (state_q == ST_ADD));
  assign n_value = (req_i.start && req_i.home) ? RIN_W'(key_i)
                                               : RIN_W'(slot_q) + RIN_W'(prod_q);

  dhrt_rem #(
    .DIVISOR (STEP_MODULUS),
    .IN_W    (SW)
  ) u_mrem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (m_start),
    .value_i (slot_i),
    .done_o  (m_done),
    .rem_o   (m_rem)
  );

  dhrt_rem #(
    .DIVISOR (TABLE_SIZE),
    .IN_W    (RIN_W)
  ) u_nrem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .value_i (n_value),
    .done_o  (n_done),
    .rem_o   (n_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      count_q <= '0;
      prod_q  <= '0;
    end else begin
      priority if (req_i.flush) begin
        state_q <= ST_IDLE;
      end else if (req_i.start) begin
        slot_q  <= slot_i;
        count_q <= count_i;
        state_q <= req_i.home ? ST_NREM : ST_MREM;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            state_q <= ST_IDLE;
          end
          ST_MREM: begin
            if (m_done) begin
              prod_q  <= PW'(m_rem) * PW'(count_q);
              state_q <= ST_ADD;
            end
          end
          ST_ADD: begin
            state_q <= ST_NREM;
          end
          ST_NREM: begin
            if (n_done) begin
              state_q <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign done_o = (state_q == ST_NREM) && n_done;
  assign slot_o = n_rem[SW-1:0];

endmodule

`default_nettype wire

// File: src/double_hash_route_table_core.sv
// Open-addressed route table keyed by a three-octet prefix, one insert or find per beat,
// one result beat per input beat. After reset the block sweeps all TABLE_SIZE slots
// (1021 by default) of the slot memory clear, one slot per cycle, while it stalls input.
// An accepted item has its home slot computed, read and evaluated; its result beat is
// registered when evaluation settles it, input stalls until then, and the next item can
// be accepted in the cycle after. Slots come from the slot-advance unit: the home slot
// takes one remainder by TABLE_SIZE, a further probe a remainder by STEP_MODULUS, a
// multiply-add and a remainder by TABLE_SIZE, each remainder a reciprocal multiply; the
// memory read of a slot overlaps with the computation of the next one.
// A result beat waits in an output register, and the next item is accepted while it
// waits; a further result holds in evaluation until that register frees.
`default_nettype none

module double_hash_route_table_core
  import dhrt_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = TABLE_SIZE_DEF,
  parameter int unsigned STEP_MODULUS = STEP_MODULUS_DEF,
  parameter int unsigned MAX_PROBES   = MAX_PROBES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  localparam int unsigned SW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(MAX_PROBES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_ISSUE,
    ST_EVAL,
    ST_NEXT
  } st_e;

  st_e        state_q;
  logic [SW-1:0] clr_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] count_q;
  in_beat_t   item_q;
  logic       out_valid_q;
  out_beat_t  out_q;

  slot_t      mem [TABLE_SIZE];
  slot_t      rdata_q;
  logic       mem_we;
  logic [SW-1:0] mem_waddr;
  slot_t      mem_wdata;
  logic       mem_re;

  step_req_t  step_req;
  logic [KEY_W-1:0] key;
  logic       step_done;
  logic [SW-1:0] step_slot;

  logic       in_accept;
  logic       out_free;
  logic       is_empty;
  logic       is_match;
  logic       is_last;
  logic       finish;
  out_beat_t  result;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign key = KEY_W'(in_beat_i.octet_a) + KEY_W'(in_beat_i.octet_b)
             + KEY_W'(in_beat_i.octet_c);

  assign is_empty = !rdata_q.valid;
  assign is_match = (item_q.op == OP_FIND) && (rdata_q.oa == item_q.octet_a)
                  && (rdata_q.ob == item_q.octet_b) && (rdata_q.oc == item_q.octet_c);
  assign is_last  = (count_q == CW'(MAX_PROBES));
  assign finish   = (state_q == ST_EVAL) && out_free && (is_empty || is_match || is_last);

  always_comb begin
    result = '0;
    priority if (is_empty) begin
      result.found = (item_q.op == OP_INSERT);
    end else if (is_match) begin
      result.found         = 1'b1;
      result.interface_out = rdata_q.ifc;
    end else begin
      result.table_full = (item_q.op == OP_INSERT);
    end
  end

  always_comb begin
    step_req.start = in_accept || (state_q == ST_ISSUE);
    step_req.home  = in_accept;
    step_req.flush = finish;
  end

  dhrt_step #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS),
    .MAX_PROBES   (MAX_PROBES)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (step_req),
    .key_i   (key),
    .slot_i  (slot_q),
    .count_i (count_q),
    .done_o  (step_done),
    .slot_o  (step_slot)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (finish && is_empty && (item_q.op == OP_INSERT)) begin
      mem_we          = 1'b1;
      mem_wdata.valid = 1'b1;
      mem_wdata.oa    = item_q.octet_a;
      mem_wdata.ob    = item_q.octet_b;
      mem_wdata.oc    = item_q.octet_c;
      mem_wdata.ifc   = item_q.interface_in;
    end
  end

  assign mem_re = (state_q == ST_ISSUE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(TABLE_SIZE - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            item_q  <= in_beat_i;
            state_q <= ST_HOME;
          end
        end
        ST_HOME: begin
          if (step_done) begin
            slot_q  <= step_slot;
            count_q <= CW'(1);
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end else if (!(is_empty || is_match || is_last)) begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (step_done) begin
            slot_q  <= step_slot;
            count_q <= count_q + CW'(1);
            state_q <= ST_ISSUE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EVAL))
    else $error("result beat loaded outside probe evaluation");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ((count_q != '0) && (count_q <= CW'(MAX_PROBES))))
    else $error("probe count out of range");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_beat_o.found && out_beat_o.table_full))
    else $error("result beat marks both found and table full");

  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> ((state_q == ST_CLEAR) || (state_q == ST_IDLE)))
    else $error("clearing sweep left for a probe state");

endmodule

`default_nettype wire
